### sv/reno_congestion_window_core_macros.svh
// Assertion macros shared by the checkers of the congestion window core.
// Stands alone: no package and no other header is needed.
`ifndef RENO_CONGESTION_WINDOW_CORE_MACROS_SVH
`define RENO_CONGESTION_WINDOW_CORE_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define RCW_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define RCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define RCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/rcw_pkg.sv
// Types and constants shared by the congestion window core modules.
// No dependencies; the csr, controller, datapath and top-level modules import this package.
package rcw_pkg;

   typedef enum logic [1:0] {
      PH_SLOW  = 2'd0,
      PH_AVOID = 2'd1,
      PH_FAST  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_APPLY,
      ST_CHECK,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_DIV_ADD,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic decode;
      logic apply;
      logic check;
      logic div_load;
      logic div_step;
      logic div_add;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic grow_pending;
      logic div_last;
      logic out_hold;
   } status_type;

   // Configuration that the datapath reads.
   typedef struct packed {
      logic [15:0] timeout_threshold;
      logic [19:0] packet_total;
      logic [2:0]  timeout_limit;
   } cfg_type;

   localparam int CSR_ADDR_BITS = 4;

   localparam logic [1:0] CSR_IDX_INIT_THR    = 2'd0;
   localparam logic [1:0] CSR_IDX_TIMEOUT_THR = 2'd1;
   localparam logic [1:0] CSR_IDX_PKT_TOTAL   = 2'd2;
   localparam logic [1:0] CSR_IDX_TO_LIMIT    = 2'd3;

   localparam logic [15:0] INIT_THR_RST    = 16'd55;
   localparam logic [15:0] TIMEOUT_THR_RST = 16'd64;
   localparam logic [19:0] PKT_TOTAL_RST   = 20'd1;
   localparam logic [2:0]  TO_LIMIT_RST    = 3'd5;

   localparam logic [2:0]  RUN_MAX     = 3'd7;
   localparam logic [1:0]  DUP_TRIGGER = 2'd3;
   localparam logic [15:0] FAST_ADD    = 16'd3;
   localparam logic [15:0] SAT16       = 16'hFFFF;
   localparam logic [31:0] WIN_MAX     = 32'hFFFF_FFFF;

endpackage

### sv/rcw_csr.sv
// Configuration registers of the congestion window core behind an APB-style port.
// Depends on rcw_pkg for register indexes, reset values and cfg_type.
module rcw_csr
   import rcw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   logic [15:0] init_thr_ff, init_thr_in;
   logic [15:0] to_thr_ff, to_thr_in;
   logic [19:0] pkt_total_ff, pkt_total_in;
   logic [2:0]  to_limit_ff, to_limit_in;
   logic        wr_en;
   logic [1:0]  idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = csr_paddr[3:2];

   always_comb begin
      init_thr_in  = init_thr_ff;
      to_thr_in    = to_thr_ff;
      pkt_total_in = pkt_total_ff;
      to_limit_in  = to_limit_ff;
      if (wr_en) begin
         case (idx)
            CSR_IDX_INIT_THR:    init_thr_in  = csr_pwdata[15:0];
            CSR_IDX_TIMEOUT_THR: to_thr_in    = csr_pwdata[15:0];
            CSR_IDX_PKT_TOTAL:   pkt_total_in = csr_pwdata[19:0];
            CSR_IDX_TO_LIMIT:    to_limit_in  = csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_thr_ff  <= INIT_THR_RST;
         to_thr_ff    <= TIMEOUT_THR_RST;
         pkt_total_ff <= PKT_TOTAL_RST;
         to_limit_ff  <= TO_LIMIT_RST;
      end else begin
         init_thr_ff  <= init_thr_in;
         to_thr_ff    <= to_thr_in;
         pkt_total_ff <= pkt_total_in;
         to_limit_ff  <= to_limit_in;
      end
   end

   always_comb begin
      case (idx)
         CSR_IDX_INIT_THR:    csr_prdata = 32'(init_thr_ff);
         CSR_IDX_TIMEOUT_THR: csr_prdata = 32'(to_thr_ff);
         CSR_IDX_PKT_TOTAL:   csr_prdata = 32'(pkt_total_ff);
         CSR_IDX_TO_LIMIT:    csr_prdata = 32'(to_limit_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg.timeout_threshold = to_thr_ff;
   assign cfg.packet_total      = pkt_total_ff;
   assign cfg.timeout_limit     = to_limit_ff;

endmodule

### sv/rcw_ctrl.sv
// Sequencing state machine of the congestion window core.
// Depends on rcw_pkg for state_type, cmd_type and status_type.
module rcw_ctrl
   import rcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_DECODE;
         ST_DECODE:   state_in = ST_APPLY;
         ST_APPLY:    state_in = ST_CHECK;
         ST_CHECK:    state_in = status.grow_pending ? ST_DIV_LOAD : ST_EMIT;
         ST_DIV_LOAD: state_in = ST_DIV_STEP;
         ST_DIV_STEP: if (status.div_last) state_in = ST_DIV_ADD;
         ST_DIV_ADD:  state_in = ST_CHECK;
         ST_EMIT:     if (!status.out_hold) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DECODE:   cmd.decode   = 1'b1;
         ST_APPLY:    cmd.apply    = 1'b1;
         ST_CHECK:    cmd.check    = 1'b1;
         ST_DIV_LOAD: cmd.div_load = 1'b1;
         ST_DIV_STEP: cmd.div_step = 1'b1;
         ST_DIV_ADD:  cmd.div_add  = 1'b1;
         ST_EMIT:     cmd.emit     = !status.out_hold;
         default: ;
      endcase
   end

endmodule

### sv/rcw_datapath.sv
// Datapath of the congestion window core: window state, event update,
// serial reciprocal divider and the result register. Depends on rcw_pkg.
module rcw_datapath
   import rcw_pkg::*;
#(
   parameter int SEQ_BITS   = 20,
   parameter int FRAC_BITS  = 16,
   parameter int ITER_LIMIT = 1024,
   localparam int OUT_W     = ((2 * SEQ_BITS + 37 + 7) / 8) * 8
)
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  cfg_type             cfg,
   input  logic                in_kind,
   input  logic [SEQ_BITS-1:0] in_ack,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [OUT_W-1:0]    rsp_tdata
);

   localparam int WW  = 32 - FRAC_BITS;
   localparam int EW  = (WW > 16) ? WW : 16;
   localparam int GW  = EW + 1;
   localparam int CW  = $clog2(ITER_LIMIT + 1);
   localparam int DM1 = (SEQ_BITS + 1 > GW) ? SEQ_BITS + 1 : GW;
   localparam int DFW = ((DM1 > CW) ? DM1 : CW) + 1;
   localparam int QW  = FRAC_BITS + 1;
   localparam int BW  = $clog2(FRAC_BITS + 1);
   localparam int AW  = ((SEQ_BITS + 1 + FRAC_BITS > 32) ? SEQ_BITS + 1 + FRAC_BITS : 32) + 1;
   localparam int TW  = 17 + FRAC_BITS;
   localparam int XW  = (TW > 33) ? TW : 33;
   localparam int PW  = (SEQ_BITS > 20) ? SEQ_BITS : 20;
   localparam int NW  = ((SEQ_BITS > WW) ? SEQ_BITS : WW) + 1;

   localparam logic [31:0]         ONE_FX   = 32'd1 << FRAC_BITS;
   localparam logic [SEQ_BITS-1:0] SEQ_MASK = {SEQ_BITS{1'b1}};
   localparam logic signed [DFW-1:0] LIMIT_S = DFW'(ITER_LIMIT);
   localparam logic signed [DFW-1:0] ZERO_S  = DFW'(0);
   localparam logic [BW-1:0]       TOP_BIT  = BW'(FRAC_BITS);

   // Architectural state.
   phase_type             phase_ff, phase_in;
   logic [31:0]           win_ff, win_in;
   logic [15:0]           thr_ff, thr_in;
   logic [1:0]            dup_ff, dup_in;
   logic [SEQ_BITS-1:0]   base_ff, base_in;
   logic [SEQ_BITS:0]     high_ff, high_in;
   logic [2:0]            run_ff, run_in;

   // Per-item control.
   logic [CW-1:0]         count_ff, count_in;
   logic                  slow_chk_ff, slow_chk_in;
   logic                  retx_ff, retx_in;
   logic                  abort_ff, abort_in;
   logic                  out_valid_ff, out_valid_in;

   // Captured item and decoded flags.
   logic                  kind_ff;
   logic [SEQ_BITS-1:0]   ack_ff;
   logic                  skip_ff, dup_hit_ff, ack_new_ff, to_abort_ff, le_one_ff;
   logic [SEQ_BITS:0]     delta_ff;
   logic signed [GW-1:0]  gap_ff;
   logic [2:0]            run_next_ff;
   logic [15:0]           thr_half_ff;
   logic [1:0]            dup_next_ff;

   // Divider.
   logic [WW-1:0]         div_d_ff;
   logic [WW-1:0]         rem_ff, rem_in;
   logic [QW-1:0]         quo_ff, quo_in;
   logic [BW-1:0]         bit_ff;

   logic [OUT_W-1:0]      out_data_ff;

   // Combinational terms.
   logic [WW-1:0]         whole;
   logic                  skip_c, dup_hit_c, ack_new_c, to_abort_c, le_one_c;
   logic [SEQ_BITS:0]     delta_c;
   logic signed [GW-1:0]  gap_c;
   logic [2:0]            run_next_c;
   logic [EW-1:0]         half_e;
   logic [15:0]           thr_half_c;
   logic signed [DFW-1:0] diff, grow_src;
   logic [CW-1:0]         grow_cnt;
   logic [AW-1:0]         sum_delta;
   logic [TW-1:0]         thr_fx, fast_fx;
   logic [31:0]           thr_win, fast_win;
   logic [32:0]           sum_one, sum_q;
   logic [SEQ_BITS-1:0]   base_next;
   logic [WW:0]           div_sh;
   logic                  div_ge;
   logic [NW-1:0]         end_sum;
   logic [SEQ_BITS-1:0]   end_val;
   logic [15:0]           whole16;

   assign whole = win_ff[31:FRAC_BITS];

   // Event decode from the state before the event.
   always_comb begin
      skip_c    = PW'(base_ff) >= PW'(cfg.packet_total);
      dup_hit_c = !high_ff[SEQ_BITS] && (ack_ff == high_ff[SEQ_BITS-1:0]);
      ack_new_c = ack_ff >= base_ff;
      if (high_ff[SEQ_BITS]) begin
         delta_c = (SEQ_BITS + 1)'(ack_ff) + 1'b1;
      end else if (ack_ff >= high_ff[SEQ_BITS-1:0]) begin
         delta_c = (SEQ_BITS + 1)'(ack_ff) - high_ff;
      end else begin
         delta_c = '0;
      end
      gap_c      = GW'(thr_ff) - GW'(whole);
      run_next_c = (run_ff == RUN_MAX) ? RUN_MAX : run_ff + 3'd1;
      to_abort_c = run_next_c >= cfg.timeout_limit;
      le_one_c   = win_ff <= ONE_FX;
      half_e     = EW'(whole >> 1);
      thr_half_c = (half_e > EW'(SAT16)) ? SAT16 : half_e[15:0];
   end

   // Arithmetic of the update and the divider step, on registered decode results and state.
   always_comb begin
      diff     = DFW'(delta_ff) - DFW'(gap_ff);
      grow_src = (phase_ff == PH_SLOW) ? diff : DFW'(delta_ff);
      if (grow_src <= ZERO_S) begin
         grow_cnt = '0;
      end else if (grow_src > LIMIT_S) begin
         grow_cnt = CW'(ITER_LIMIT);
      end else begin
         grow_cnt = CW'(grow_src);
      end
      sum_delta = AW'(win_ff) + (AW'(delta_ff) << FRAC_BITS);
      thr_fx    = TW'(thr_ff) << FRAC_BITS;
      fast_fx   = (TW'(thr_half_ff) + TW'(FAST_ADD)) << FRAC_BITS;
      thr_win   = (XW'(thr_fx) > XW'(WIN_MAX)) ? WIN_MAX : 32'(thr_fx);
      fast_win  = (XW'(fast_fx) > XW'(WIN_MAX)) ? WIN_MAX : 32'(fast_fx);
      sum_one   = 33'(win_ff) + 33'(ONE_FX);
      sum_q     = 33'(win_ff) + 33'(quo_ff);
      base_next = (ack_ff == SEQ_MASK) ? SEQ_MASK : ack_ff + 1'b1;
      div_sh    = {rem_ff, (bit_ff == TOP_BIT)};
      div_ge    = div_sh >= {1'b0, div_d_ff};
   end

   always_comb begin
      phase_in     = phase_ff;
      win_in       = win_ff;
      thr_in       = thr_ff;
      dup_in       = dup_ff;
      base_in      = base_ff;
      high_in      = high_ff;
      run_in       = run_ff;
      count_in     = count_ff;
      slow_chk_in  = slow_chk_ff;
      retx_in      = retx_ff;
      abort_in     = abort_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      out_valid_in = out_valid_ff && !rsp_tready;

      if (cmd.load) begin
         retx_in     = 1'b0;
         abort_in    = 1'b0;
         slow_chk_in = 1'b0;
      end

      if (cmd.apply && !skip_ff) begin
         if (kind_ff) begin
            run_in = run_next_ff;
            if (to_abort_ff) begin
               abort_in = 1'b1;
            end else begin
               thr_in   = le_one_ff ? cfg.timeout_threshold : thr_half_ff;
               win_in   = ONE_FX;
               dup_in   = '0;
               phase_in = PH_SLOW;
               retx_in  = 1'b1;
            end
         end else begin
            run_in = '0;
            if (dup_hit_ff) begin
               if (phase_ff == PH_FAST) begin
                  win_in = sum_one[32] ? WIN_MAX : sum_one[31:0];
               end else begin
                  dup_in = dup_next_ff;
                  if (dup_next_ff == DUP_TRIGGER) begin
                     thr_in   = thr_half_ff;
                     win_in   = fast_win;
                     phase_in = PH_FAST;
                     retx_in  = 1'b1;
                  end
               end
            end else if (ack_new_ff) begin
               case (phase_ff)
                  PH_SLOW: begin
                     if (diff > ZERO_S) begin
                        // Threshold crossed inside this ack: the rest grows in avoidance.
                        win_in   = thr_win;
                        count_in = grow_cnt;
                        phase_in = PH_AVOID;
                     end else begin
                        win_in      = (sum_delta > AW'(WIN_MAX)) ? WIN_MAX : 32'(sum_delta);
                        slow_chk_in = 1'b1;
                     end
                  end
                  PH_AVOID: count_in = grow_cnt;
                  PH_FAST: begin
                     win_in   = thr_win;
                     phase_in = PH_AVOID;
                  end
                  default: ;
               endcase
               dup_in  = '0;
               base_in = base_next;
               high_in = {1'b0, ack_ff};
            end
         end
      end

      if (cmd.check && slow_chk_ff) begin
         if (EW'(whole) >= EW'(thr_ff)) phase_in = PH_AVOID;
         slow_chk_in = 1'b0;
      end

      if (cmd.div_load) begin
         rem_in = '0;
         quo_in = '0;
      end

      if (cmd.div_step) begin
         rem_in = div_ge ? WW'(div_sh - {1'b0, div_d_ff}) : div_sh[WW-1:0];
         quo_in = {quo_ff[QW-2:0], div_ge};
      end

      if (cmd.div_add) begin
         win_in   = sum_q[32] ? WIN_MAX : sum_q[31:0];
         count_in = count_ff - 1'b1;
      end

      if (cmd.emit) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SLOW;
         win_ff       <= ONE_FX;
         thr_ff       <= INIT_THR_RST;
         dup_ff       <= '0;
         base_ff      <= '0;
         high_ff      <= '1;
         run_ff       <= '0;
         count_ff     <= '0;
         slow_chk_ff  <= 1'b0;
         retx_ff      <= 1'b0;
         abort_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         win_ff       <= win_in;
         thr_ff       <= thr_in;
         dup_ff       <= dup_in;
         base_ff      <= base_in;
         high_ff      <= high_in;
         run_ff       <= run_in;
         count_ff     <= count_in;
         slow_chk_ff  <= slow_chk_in;
         retx_ff      <= retx_in;
         abort_ff     <= abort_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= in_kind;
         ack_ff  <= in_ack;
      end
      if (cmd.decode) begin
         skip_ff     <= skip_c;
         dup_hit_ff  <= dup_hit_c;
         ack_new_ff  <= ack_new_c;
         to_abort_ff <= to_abort_c;
         le_one_ff   <= le_one_c;
         delta_ff    <= delta_c;
         gap_ff      <= gap_c;
         run_next_ff <= run_next_c;
         thr_half_ff <= thr_half_c;
         dup_next_ff <= dup_ff + 2'd1;
      end
      if (cmd.div_load) begin
         // A window below one whole packet divides by one.
         div_d_ff <= (whole == '0) ? WW'(1) : whole;
         bit_ff   <= TOP_BIT;
      end
      if (cmd.div_step) bit_ff <= bit_ff - 1'b1;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.emit) out_data_ff <= OUT_W'({abort_ff, skip_c, thr_ff, whole16, 2'(phase_ff),
                                           retx_ff, end_val, base_ff});
   end

   always_comb begin
      end_sum = NW'(base_ff) + NW'(whole);
      end_val = (end_sum > NW'(SEQ_MASK)) ? SEQ_MASK : end_sum[SEQ_BITS-1:0];
      whole16 = (EW'(whole) > EW'(SAT16)) ? SAT16 : 16'(whole);
   end

   assign status.grow_pending = count_ff != '0;
   assign status.div_last     = bit_ff == '0;
   assign status.out_hold     = out_valid_ff && !rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

### sv/reno_congestion_window_core.sv
// Top level of the Reno-style congestion window core.
// Depends on rcw_pkg, rcw_csr, rcw_ctrl and rcw_datapath.
//
//   Channel   Direction  Handshake            Contents
//   req_      in         tvalid/tready        one event: ack or receive timeout
//   rsp_      out        tvalid/tready        window bounds, flags, phase, threshold
//   csr_      in/out     psel/penable/pready  four configuration registers
//
// Accepted in the idle state, an item passes through decode, apply and check; then, for
// each of n avoidance increments it causes (at most ITER_LIMIT), through a divider load, the
// steps of a serial restoring division of 2^FRAC_BITS by floor(window), one bit per cycle, and
// an add and a new check. Its result is registered in emit, before the next item is taken.
// Reset is synchronous and needs no clearing pass. A stalled result holds its value; the
// next item is still taken and worked on, but its result waits, holding off the input.
module reno_congestion_window_core
   import rcw_pkg::*;
#(
   parameter int SEQ_BITS   = 20,
   parameter int FRAC_BITS  = 16,
   parameter int ITER_LIMIT = 1024,
   localparam int IN_W      = ((SEQ_BITS + 7) / 8) * 8,
   localparam int OUT_W     = ((2 * SEQ_BITS + 37 + 7) / 8) * 8
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // ack_number in the lowest SEQ_BITS bits, zero above.
   input  logic [IN_W-1:0]          req_tdata,
   // event_kind: 0 acknowledgement, 1 receive timeout.
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // From bit 0 up: window_base, window_end, retransmit, phase, window_whole,
   // threshold, transfer_done, abort, then zero fill.
   output logic [OUT_W-1:0]         rsp_tdata,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // Register file; only the datapath-visible fields leave it.
   rcw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The controller sequences decode, update, the divide loop and the result write.
   rcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the window state and the output register.
   rcw_datapath #(
      .SEQ_BITS   (SEQ_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .ITER_LIMIT (ITER_LIMIT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg),
      .in_kind    (req_tuser),
      .in_ack     (req_tdata[SEQ_BITS-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### sv/rcw_checker.sv
// Port-level checks of the congestion window core, bound to the top level.
// Depends on reno_congestion_window_core_macros.svh.
`include "reno_congestion_window_core_macros.svh"

module rcw_checker #(
   parameter int SEQ_BITS = 20,
   localparam int OUT_W   = ((2 * SEQ_BITS + 37 + 7) / 8) * 8
)
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [OUT_W-1:0] rsp_tdata
);

   localparam int RETX_BIT  = 2 * SEQ_BITS;
   localparam int PH_LO     = 2 * SEQ_BITS + 1;
   localparam int ABORT_BIT = 2 * SEQ_BITS + 36;

   logic [SEQ_BITS-1:0] base_f, end_f;
   logic [1:0]          phase_f;

   assign base_f  = rsp_tdata[SEQ_BITS-1:0];
   assign end_f   = rsp_tdata[2*SEQ_BITS-1:SEQ_BITS];
   assign phase_f = rsp_tdata[PH_LO+1:PH_LO];

   // The core finishes one item before it takes the next.
   `RCW_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "accepted a second item while busy")

   `RCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `RCW_ASSERT_NEVER(a_retx_abort, clock, reset, rsp_tvalid && rsp_tdata[RETX_BIT] && rsp_tdata[ABORT_BIT], "retransmit together with abort")

   `RCW_ASSERT_NOW(a_phase_code, clock, reset, rsp_tvalid, phase_f != 2'd3, "phase code out of range")

   `RCW_ASSERT_NOW(a_end_order, clock, reset, rsp_tvalid, end_f >= base_f, "window end below window base")

endmodule

bind reno_congestion_window_core rcw_checker #(.SEQ_BITS(SEQ_BITS)) u_checker (.*);
